@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the heading unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define MCH_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("assertion failed");

// Next-cycle implication, checked through reset as well.
`define MCH_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) (ant) |=> (con)) \
    else $error("assertion failed");

`endif

@@ hdl/mch_pkg.sv @@
package mch_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int NSTEP        = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  localparam int RAW_W   = 16;
  localparam int REG_W   = 11;
  localparam int AXIS_W  = 27;
  localparam int HEAD_W  = 9;
  localparam int VEC_W   = 54;
  localparam int ANG_W   = 27;
  localparam int PRESHIFT = 24;
  localparam int ANG_FRAC = 16;

  localparam int NUM_AXES = 3;

  // Configuration register indexes.
  localparam logic [1:0] REG_SCALE_NUM = 2'd0;
  localparam logic [1:0] REG_SCALE_DEN = 2'd1;

  localparam logic [REG_W-1:0] SCALE_NUM_RST = 11'd3;
  localparam logic [REG_W-1:0] SCALE_DEN_RST = 11'd2;

  localparam logic signed [ANG_W-1:0] ANG_180 = 27'sd11796480;
  localparam logic signed [ANG_W-1:0] ANG_360 = 27'sd23592960;
  localparam logic [HEAD_W-1:0] HEAD_MAX = 9'd359;

  // round(atan(2^-i) in degrees * 65536)
  localparam logic [21:0] ATAN_Q16 [ATAN_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
    22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
  };

  typedef logic signed [RAW_W-1:0]  raw_t;
  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [ANG_W-1:0]  ang_t;

endpackage

@@ hdl/mch_scale.sv @@
module mch_scale (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mch_pkg::raw_t                  raw   [mch_pkg::NUM_AXES],
  input  logic [mch_pkg::REG_W-1:0]      num,
  input  logic [mch_pkg::REG_W-1:0]      den,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mch_pkg::axis_t                 axis  [mch_pkg::NUM_AXES]
);

  // One stage for the product, one per quotient bit, one for the sign.
  localparam int NS = mch_pkg::AXIS_W + 2;
  localparam int AW = mch_pkg::AXIS_W;
  localparam int RW = mch_pkg::REG_W;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;
  logic [AW-1:0] dq_r  [NS-1][mch_pkg::NUM_AXES];
  logic [RW-1:0] rem_r [NS-1][mch_pkg::NUM_AXES];
  logic          neg_r [NS-1][mch_pkg::NUM_AXES];
  mch_pkg::axis_t axis_r [mch_pkg::NUM_AXES];
  logic [RW-1:0] den_eff;

  assign den_eff = (den == '0) ? RW'(1) : den;

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = ~v_r[k] | rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  for (genvar a = 0; a < mch_pkg::NUM_AXES; a++) begin : g_axis
    logic [mch_pkg::RAW_W:0] mag_in;
    logic [AW-1:0]           prod;

    always_comb begin
      mag_in = raw[a][mch_pkg::RAW_W-1] ? -{1'b1, raw[a]} : {1'b0, raw[a]};
      prod   = AW'(mag_in) * AW'(num);
    end

    always_ff @(posedge clk) begin
      if (rdy[0]) begin
        dq_r[0][a]  <= prod;
        rem_r[0][a] <= '0;
        neg_r[0][a] <= raw[a][mch_pkg::RAW_W-1];
      end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar k = 1; k <= AW; k++) begin : g_div
      logic [RW:0] t;
      logic        ge;
      always_comb begin
        t  = {rem_r[k-1][a], dq_r[k-1][a][AW-1]};
        ge = (t >= {1'b0, den_eff});
      end
      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          rem_r[k][a] <= ge ? RW'(t - {1'b0, den_eff}) : t[RW-1:0];
          dq_r[k][a]  <= {dq_r[k-1][a][AW-2:0], ge};
          neg_r[k][a] <= neg_r[k-1][a];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[NS-1]) begin
        axis_r[a] <= neg_r[NS-2][a] ? -$signed(dq_r[NS-2][a]) : $signed(dq_r[NS-2][a]);
      end
    end
    assign axis[a] = axis_r[a];
  end

endmodule

@@ hdl/mch_cordic.sv @@
module mch_cordic (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mch_pkg::axis_t axis_in  [mch_pkg::NUM_AXES],
  output logic           out_valid,
  input  logic           out_ready,
  output mch_pkg::axis_t axis_out [mch_pkg::NUM_AXES],
  output logic [mch_pkg::HEAD_W-1:0] heading
);

  // Setup stage, one stage per rotation, one stage for the degree conversion.
  localparam int NC = mch_pkg::NSTEP + 2;

  logic [NC-1:0]  v_r;
  logic [NC:0]    rdy;
  mch_pkg::vec_t  x_r   [NC-1];
  mch_pkg::vec_t  y_r   [NC-1];
  mch_pkg::ang_t  z_r   [NC-1];
  logic           zero_r[NC-1];
  mch_pkg::axis_t ax_r  [NC][mch_pkg::NUM_AXES];
  logic [mch_pkg::HEAD_W-1:0] head_r;

  always_comb begin
    rdy[NC] = out_ready;
    for (int k = NC - 1; k >= 0; k--) begin
      rdy[k] = ~v_r[k] | rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NC-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NC; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Axes ride along with the angle.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ax_r[0] <= axis_in;
    end
    for (int k = 1; k < NC; k++) begin
      if (rdy[k]) begin
        ax_r[k] <= ax_r[k-1];
      end
    end
  end

  // Fold the left half plane onto the right half, starting at 180 degrees.
  mch_pkg::vec_t x0, y0;
  always_comb begin
    x0 = $signed({{3{axis_in[0][mch_pkg::AXIS_W-1]}}, axis_in[0], 24'b0});
    y0 = $signed({{3{axis_in[1][mch_pkg::AXIS_W-1]}}, axis_in[1], 24'b0});
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x_r[0]    <= x0[mch_pkg::VEC_W-1] ? -x0 : x0;
      y_r[0]    <= x0[mch_pkg::VEC_W-1] ? -y0 : y0;
      z_r[0]    <= x0[mch_pkg::VEC_W-1] ? mch_pkg::ANG_180 : '0;
      zero_r[0] <= (axis_in[0] == '0) && (axis_in[1] == '0);
    end
  end

  for (genvar i = 0; i < mch_pkg::NSTEP; i++) begin : g_rot
    mch_pkg::ang_t a_i;
    assign a_i = $signed({5'b0, mch_pkg::ATAN_Q16[i]});
    always_ff @(posedge clk) begin
      if (rdy[i+1]) begin
        if (!y_r[i][mch_pkg::VEC_W-1]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + a_i;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - a_i;
        end
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  mch_pkg::ang_t zw;
  logic [mch_pkg::HEAD_W-1:0] hw;
  always_comb begin
    zw = z_r[NC-2][mch_pkg::ANG_W-1] ? z_r[NC-2] + mch_pkg::ANG_360 : z_r[NC-2];
    if (zw[mch_pkg::ANG_W-1]) begin
      zw = '0;
    end
    hw = zw[mch_pkg::ANG_FRAC+mch_pkg::HEAD_W-1:mch_pkg::ANG_FRAC];
    if (hw > mch_pkg::HEAD_MAX) begin
      hw = mch_pkg::HEAD_MAX;
    end
    if (zero_r[NC-2]) begin
      hw = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NC-1]) begin
      head_r <= hw;
    end
  end

  assign heading = head_r;
  for (genvar a = 0; a < mch_pkg::NUM_AXES; a++) begin : g_out
    assign axis_out[a] = ax_r[NC-1][a];
  end

endmodule

@@ hdl/magnetometer_compass_heading_unit.sv @@
// The scaling pipeline feeds the heading pipeline; each division bit and each rotation has
// its own stage. Throughput: one item per cycle while the output is not stalled.
// A stall at the output is absorbed by empty stages before the input is held off.
// Reset (rst_n low, synchronous) empties the pipeline and sets scale_num to 3, scale_den to 2.
`include "assert_macros.svh"

module magnetometer_compass_heading_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // x_low, x_high, y_low, y_high, z_low, z_high
  input  logic        in_tuser,   // read_failed
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // x_scaled, y_scaled, z_scaled, heading_deg, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  logic [mch_pkg::REG_W-1:0] scale_num_r, scale_den_r;
  mch_pkg::raw_t  raw  [mch_pkg::NUM_AXES];
  mch_pkg::axis_t mid  [mch_pkg::NUM_AXES];
  mch_pkg::axis_t fin  [mch_pkg::NUM_AXES];
  logic mid_valid, mid_ready;
  logic [mch_pkg::HEAD_W-1:0] heading;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_num_r <= mch_pkg::SCALE_NUM_RST;
      scale_den_r <= mch_pkg::SCALE_DEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        mch_pkg::REG_SCALE_NUM: scale_num_r <= cfg_data;
        mch_pkg::REG_SCALE_DEN: scale_den_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A failed read enters as an all-zero sample.
  for (genvar a = 0; a < mch_pkg::NUM_AXES; a++) begin : g_raw
    assign raw[a] = in_tuser ? '0 : $signed(in_tdata[16*a +: 16]);
  end

  mch_scale u_scale (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .raw(raw),
    .num(scale_num_r), .den(scale_den_r),
    .out_valid(mid_valid), .out_ready(mid_ready), .axis(mid)
  );

  mch_cordic u_cordic (
    .clk(clk), .rst_n(rst_n),
    .in_valid(mid_valid), .in_ready(mid_ready), .axis_in(mid),
    .out_valid(out_tvalid), .out_ready(out_tready), .axis_out(fin),
    .heading(heading)
  );

  assign out_tdata = {6'b0, heading, fin[2], fin[1], fin[0]};

  `MCH_ASSERT_IMP(a_head_range, out_tvalid, out_tdata[89:81] <= mch_pkg::HEAD_MAX)
  `MCH_ASSERT_IMP(a_head_origin, out_tvalid && out_tdata[26:0] == '0 && out_tdata[53:27] == '0,
                  out_tdata[89:81] == '0)
  `MCH_ASSERT_NXT(a_reset_empty, !rst_n, !out_tvalid)

endmodule
